/* src/isr_pkg.sv */
// Shared constants and controller-to-datapath types for the integer square root block.
package isr_pkg;

    localparam int RADICAND_W           = 64;
    localparam int ROOT_W               = 32;
    localparam int RADICAND_BITS_DEFAULT = 64;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } isr_cmd_t;

endpackage

/* src/isr_in_if.sv */
// Input channel: one radicand per transaction.
interface isr_in_if;
    import isr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [RADICAND_W-1:0] radicand;

    modport source (output valid, output radicand, input ready);
    modport sink   (input valid, input radicand, output ready);
endinterface

/* src/isr_out_if.sv */
// Output channel: one root and exactness flag per transaction.
interface isr_out_if;
    import isr_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROOT_W-1:0] root;
    logic              is_exact;

    modport source (output valid, output root, output is_exact, input ready);
    modport sink   (input valid, input root, input is_exact, output ready);
endinterface

/* src/isr_ctrl.sv */
// Sequencing FSM: accepts a radicand, counts the root-bit steps, publishes the result.
module isr_ctrl #(
    parameter int STEPS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output isr_pkg::isr_cmd_t cmd
);
    import isr_pkg::*;

    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;
    logic             last;

    assign slot_free = !out_valid_reg || out_ready;
    assign last      = (cnt_reg == CNT_LAST);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (!last)
                begin
                    cmd.step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (slot_free)
                begin
                    cmd.step       = 1'b1;
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Never overwrite a result that has not been taken.
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || out_ready))
        else $error("publish while output slot busy");

    // A load always starts a fresh step count.
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_RUN) && (cnt_reg == '0))
        else $error("load did not start run");

    // Publish only on the final step.
    a_publish_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (state_reg == S_RUN) && last && cmd.step)
        else $error("publish before last step");

    // Step counter stays within the step range.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST)
        else $error("step counter out of range");
endmodule

/* src/isr_dpath.sv */
// Restoring radix-2 square root datapath, one root bit per step, with output register.
module isr_dpath #(
    parameter int RADICAND_BITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  isr_pkg::isr_cmd_t              cmd,
    input  logic [isr_pkg::RADICAND_W-1:0] radicand,
    output logic [isr_pkg::ROOT_W-1:0]     root,
    output logic                           is_exact
);
    import isr_pkg::*;

    localparam int STEPS = (RADICAND_BITS + 1) / 2;
    localparam int W     = 2 * STEPS;
    localparam logic [W-1:0] BIT_INIT = W'(1) << (W - 2);

    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      acc_reg, acc_next;
    logic [W-1:0]      bit_reg, bit_next;
    logic [W-1:0]      trial;
    logic [W-1:0]      rad_w;
    logic              ge;
    logic [ROOT_W-1:0] root_reg;
    logic              exact_reg;

    assign rad_w = W'(radicand[RADICAND_BITS-1:0]);
    assign trial = acc_reg + bit_reg;
    assign ge    = (rem_reg >= trial);

    always_comb
    begin
        rem_next = rem_reg;
        acc_next = acc_reg;
        bit_next = bit_reg;
        if (cmd.load)
        begin
            rem_next = rad_w;
            acc_next = '0;
            bit_next = BIT_INIT;
        end
        else if (cmd.step)
        begin
            rem_next = ge ? (rem_reg - trial) : rem_reg;
            acc_next = ge ? ((acc_reg >> 1) + bit_reg) : (acc_reg >> 1);
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        bit_reg <= bit_next;
        if (cmd.publish)
        begin
            root_reg  <= ROOT_W'(acc_next[STEPS-1:0]);
            exact_reg <= (rem_next == '0);
        end
    end

    assign root     = root_reg;
    assign is_exact = exact_reg;

    // The trial bit walks down as a single set bit.
    a_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.load) |-> $onehot(bit_reg))
        else $error("trial bit not one-hot after load");

    // Partial root never exceeds the step span after publish.
    a_root_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> (acc_reg >> STEPS) == '0)
        else $error("root wider than step count");
endmodule

/* src/integer_square_root_64.sv */
// Top level of the 64-bit floor integer square root block.
//
//  channel   role   payload               transaction
//  operand   sink   radicand[63:0]        valid && ready
//  result    source root[31:0], is_exact  valid && ready
//
// Each root bit is resolved by the single shared add/compare/subtract unit,
// one root bit per cycle while running; the final step waits until the
// result slot is free.
// Reset is asynchronous active low and clears only the FSM and output valid.
// A stalled result holds the final step; operand is taken once the FSM is idle.
module integer_square_root_64 #(
    parameter int RADICAND_BITS = isr_pkg::RADICAND_BITS_DEFAULT
) (
    input logic     clk,
    input logic     rst_n,
    isr_in_if.sink  operand,
    isr_out_if.source result
);
    import isr_pkg::*;

    localparam int STEPS = (RADICAND_BITS + 1) / 2;

    isr_cmd_t cmd;

    isr_ctrl #(
        .STEPS (STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operand.valid),
        .in_ready  (operand.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    isr_dpath #(
        .RADICAND_BITS (RADICAND_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .radicand (operand.radicand),
        .root     (result.root),
        .is_exact (result.is_exact)
    );
endmodule

/* dv/integer_square_root_64_test.sv */
// Testbench for integer_square_root_64: directed and random radicands vs a floor-root predictor.
`timescale 1ns / 100ps

module integer_square_root_64_test;
    import isr_pkg::*;

    localparam int RADICAND_BITS = RADICAND_BITS_DEFAULT;
    localparam int PHASE_ITEMS   = 340;
    localparam int SETTLE_CYCLES = 2 * ((RADICAND_BITS + 1) / 2 + 1);

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              is_exact;
    } root_result_t;

    class root_scoreboard;
        root_result_t expected_roots[$];
        int unsigned  errors;

        function root_result_t floor_root(logic [RADICAND_W-1:0] radicand);
            logic [RADICAND_W-1:0] rem;
            logic [RADICAND_W-1:0] acc;
            logic [RADICAND_W-1:0] probe;
            logic [RADICAND_W-1:0] trial;
            logic [RADICAND_W-1:0] mask;
            int                    steps;
            root_result_t          res;
            mask  = (RADICAND_BITS >= RADICAND_W) ? '1 : ((64'd1 << RADICAND_BITS) - 64'd1);
            rem   = radicand & mask;
            acc   = '0;
            steps = (RADICAND_BITS + 1) / 2;
            probe = 64'd1 << (2 * (steps - 1));
            for (int i = 0; i < steps; i++)
            begin
                trial = acc + probe;
                if (rem >= trial)
                begin
                    rem = rem - trial;
                    acc = (acc >> 1) + probe;
                end
                else
                begin
                    acc = acc >> 1;
                end
                probe = probe >> 2;
            end
            res.root     = acc[ROOT_W-1:0];
            res.is_exact = (rem == '0);
            return res;
        endfunction

        function void note_radicand(logic [RADICAND_W-1:0] radicand);
            expected_roots.insert(expected_roots.size(), floor_root(radicand));
        endfunction

        function void check_result(logic [ROOT_W-1:0] root, logic is_exact);
            root_result_t exp_res;
            if (expected_roots.size() == 0)
            begin
                $display("%0t: unexpected result root=%0d is_exact=%0b", $time, root, is_exact);
                errors++;
                return;
            end
            exp_res = expected_roots.pop_front();
            if (root !== exp_res.root)
            begin
                $display("%0t: root mismatch expected=%0d actual=%0d",
                         $time, exp_res.root, root);
                errors++;
            end
            if (is_exact !== exp_res.is_exact)
            begin
                $display("%0t: is_exact mismatch expected=%0b actual=%0b",
                         $time, exp_res.is_exact, is_exact);
                errors++;
            end
        endfunction

        function int pending();
            return expected_roots.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;

    root_scoreboard board = new;

    isr_in_if  operand_if ();
    isr_out_if result_if ();

    integer_square_root_64 #(
        .RADICAND_BITS(RADICAND_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .operand(operand_if.sink),
        .result(result_if.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

    // operand monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && operand_if.valid && operand_if.ready)
                board.note_radicand(operand_if.radicand);
        end
    end

    // result sink: random backpressure and checking
    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
                board.check_result(result_if.root, result_if.is_exact);
            result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic offer_radicand(input logic [RADICAND_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            operand_if.valid <= 1'b0;
            @(posedge clk);
        end
        operand_if.valid    <= 1'b1;
        operand_if.radicand <= value;
        do
            @(posedge clk);
        while (!operand_if.ready);
    endtask

    function automatic logic [RADICAND_W-1:0] random_radicand();
        logic [ROOT_W-1:0]     base;
        logic [RADICAND_W-1:0] sq;
        logic [RADICAND_W-1:0] offset;
        offset = 64'($urandom_range(2)) - 64'd1;
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1:
            begin
                base = $urandom;
                sq   = 64'(base) * 64'(base);
                return sq + offset;
            end
            2: return {$urandom, $urandom} >> $urandom_range(63);
            default:
            begin
                base = $urandom_range(65535);
                sq   = 64'(base) * 64'(base);
                return sq + offset;
            end
        endcase
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            offer_radicand(random_radicand());
    endtask

    task automatic drain_results();
        operand_if.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [RADICAND_W-1:0] corner_values[$];

        corner_values = '{
            64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd8, 64'd9, 64'd15, 64'd16, 64'd17,
            64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
            64'hFFFF_FFFE_0000_0001, 64'hFFFF_FFFE_0000_0000, 64'hFFFF_FFFE_0000_0002,
            64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h3FFF_FFFF_FFFF_FFFF,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
            64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF
        };

        rst_n               <= 1'b0;
        operand_if.valid    <= 1'b0;
        operand_if.radicand <= '0;
        send_idle_pct = 14;
        recv_idle_pct = 79;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_values[i])
            offer_radicand(corner_values[i]);
        run_random(PHASE_ITEMS);
        drain_results();

        send_idle_pct = 79;
        recv_idle_pct = 14;
        run_random(PHASE_ITEMS);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
